[hw/rtl/bfh_pkg.sv]
// Package for the bloom filter hash/insert/probe block.
// Sizes, hash constants, shared types and small helper functions.
// No dependencies.
package bfh_pkg;

	localparam int FILTER_BITS = 65536;
	localparam int BIT_W       = $clog2(FILTER_BITS);
	localparam int STORE_BYTES = (FILTER_BITS + 7) / 8;
	localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
	localparam int LOG2_W      = 5;
	localparam int CNT_W       = 32;
	localparam int HASH_W      = 32;

	localparam logic [LOG2_W-1:0] LOG2_RESET = LOG2_W'(16);
	localparam int                LOG2_MIN   = 3;

	localparam logic [HASH_W-1:0] MUR_C1   = 32'hcc9e2d51;
	localparam logic [HASH_W-1:0] MUR_C2   = 32'h1b873593;
	localparam logic [HASH_W-1:0] MUR_SEED = 32'h9747b28c;
	localparam logic [HASH_W-1:0] FMIX_C1  = 32'h85ebca6b;
	localparam logic [HASH_W-1:0] FMIX_C2  = 32'hc2b2ae35;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_RD2,
		ST_UPD,
		ST_PUT
	} state_t;

	typedef struct packed {
		logic probe;
		logic start_batch;
	} item_t;

	typedef struct packed {
		logic [HASH_W-1:0] hash;
		logic              may_match;
		logic [CNT_W-1:0]  match_count;
	} res_t;

	// bit index mask: sizes below the minimum act as the minimum,
	// sizes beyond the store are cut off by the mask width itself
	function automatic logic [BIT_W-1:0] idx_mask(input logic [LOG2_W-1:0] lg);
		logic [BIT_W-1:0] m;
		for (int i = 0; i < BIT_W; i++) begin
			m[i] = (i < LOG2_MIN) || (LOG2_W'(i) < lg);
		end
		return m;
	endfunction

	function automatic logic [ADDR_W-1:0] byte_addr(input logic [BIT_W-1:0] b);
		return ADDR_W'(b >> 3);
	endfunction

endpackage

[hw/rtl/bfh_ram.sv]
// Generic simple dual-port RAM: one write port, one read port,
// read data registered. No dependencies.
module bfh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read during write to the same entry returns the old data
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/bfh_hash.sv]
// Four-stage key hash pipeline: murmur3 key mix followed by fmix32.
// One register after each 32x32 multiply. Depends on bfh_pkg.
module bfh_hash
	import bfh_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [HASH_W-1:0] in_key,
	output logic              hash_valid,
	output logic [HASH_W-1:0] hash
);

	logic              v_s1, v_s2, v_s3, v_s4;
	logic [HASH_W-1:0] p_s1, p_s2, p_s3, p_s4;
	logic [HASH_W-1:0] rot;
	logic [HASH_W-1:0] x1, x2;
	logic [HASH_W-1:0] y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_comb begin
		rot = {p_s1[HASH_W-16:0], p_s1[HASH_W-1:HASH_W-15]};
		x1  = p_s2 ^ MUR_SEED;
		x2  = x1 ^ (x1 >> 16);
		y   = p_s3 ^ (p_s3 >> 13);
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			p_s1 <= in_key * MUR_C1;
		end
		if (v_s1) begin
			p_s2 <= rot * MUR_C2;
		end
		if (v_s2) begin
			p_s3 <= x2 * FMIX_C1;
		end
		if (v_s3) begin
			p_s4 <= y * FMIX_C2;
		end
	end

	assign hash_valid = v_s4;
	assign hash       = p_s4 ^ (p_s4 >> 16);

endmodule

[hw/rtl/bfh_core.sv]
// Filter control: read-modify-write sequencer around the byte-wide bit
// store, clearing pass after reset, batch match counter and size register.
// Depends on bfh_pkg and bfh_ram.
module bfh_core
	import bfh_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [LOG2_W-1:0] cfg_wdata,
	input  logic              item_accept,
	input  item_t             item,
	output logic              ready,
	input  logic              hash_valid,
	input  logic [HASH_W-1:0] hash,
	output logic              res_valid,
	input  logic              res_take,
	output res_t              res
);

	state_t            state_q, state_d;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [LOG2_W-1:0] lg_q;
	item_t             item_q;
	logic [HASH_W-1:0] hash_q;
	logic [BIT_W-1:0]  b1_q, b2_q;
	logic [7:0]        byte1_q;
	logic              bit1_q;
	logic              hit_q;
	logic [CNT_W-1:0]  cnt_q;

	logic [BIT_W-1:0]  mask;
	logic [BIT_W-1:0]  b1_new, b2_new;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [7:0]        ram_wdata, ram_rdata;
	logic [7:0]        byte1_upd;
	logic [7:0]        byte2_cur;
	logic              bit2;
	logic              hit;
	logic [CNT_W-1:0]  cnt_base, cnt_d;
	logic              clr_last;

	bfh_ram #(
		.WIDTH(8),
		.DEPTH(STORE_BYTES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		mask     = idx_mask(lg_q);
		b1_new   = hash[BIT_W-1:0] & mask;
		b2_new   = BIT_W'(hash >> 16) & mask;
		clr_last = (clr_addr_q == ADDR_W'(STORE_BYTES - 1));
		// first byte as read, with bit 1 set on insert
		byte1_upd = ram_rdata | (item_q.probe ? 8'h00 : (8'h01 << b1_q[2:0]));
		// second read was issued while the first byte was written back
		byte2_cur = (byte_addr(b1_q) == byte_addr(b2_q)) ? byte1_q : ram_rdata;
		bit2      = byte2_cur[b2_q[2:0]];
		hit       = item_q.probe & bit1_q & bit2;
		cnt_base  = item_q.start_batch ? '0 : cnt_q;
		cnt_d     = (hit && (cnt_base != CNT_MAX)) ? cnt_base + CNT_W'(1) : cnt_base;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_last) state_d = ST_IDLE;
			ST_IDLE:  if (item_accept) state_d = ST_HASH;
			ST_HASH:  if (hash_valid) state_d = ST_RD2;
			ST_RD2:   state_d = ST_UPD;
			ST_UPD:   state_d = ST_PUT;
			ST_PUT:   if (res_take) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	// memory and handshake controls
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_addr_q;
		ram_wdata = 8'h00;
		ram_raddr = byte_addr(b1_new);
		ready     = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_IDLE: begin
				ready = 1'b1;
			end
			ST_HASH: begin
				ram_raddr = byte_addr(b1_new);
			end
			ST_RD2: begin
				ram_raddr = byte_addr(b2_q);
				ram_we    = !item_q.probe;
				ram_waddr = byte_addr(b1_q);
				ram_wdata = byte1_upd;
			end
			ST_UPD: begin
				ram_we    = !item_q.probe;
				ram_waddr = byte_addr(b2_q);
				ram_wdata = byte2_cur | (8'h01 << b2_q[2:0]);
			end
			ST_PUT: begin
				res_valid = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			lg_q       <= LOG2_RESET;
			cnt_q      <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			end
			if (cfg_we) begin
				lg_q <= cfg_wdata;
			end
			if (state_q == ST_UPD) begin
				cnt_q <= cnt_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_accept) begin
			item_q <= item;
		end
		if (state_q == ST_HASH && hash_valid) begin
			hash_q <= hash;
			b1_q   <= b1_new;
			b2_q   <= b2_new;
		end
		if (state_q == ST_RD2) begin
			byte1_q <= byte1_upd;
			bit1_q  <= ram_rdata[b1_q[2:0]];
		end
		if (state_q == ST_UPD) begin
			hit_q <= hit;
		end
	end

	always_comb begin
		res.hash        = hash_q;
		res.may_match   = hit_q;
		res.match_count = cnt_q;
	end

endmodule

[hw/rtl/bloom_filter_hash_insert_probe.sv]
// Two-bit bloom filter with murmur3-style key hash, insert and probe.
// One transaction at a time: s_axis_tready is high only in the idle state.
// Each item passes the 4-stage hash pipeline, a read and a read-modify-write
// pass over the byte store and the result hand-off (which waits on m_axis_tready).
// Reset: after arst_n releases, a clearing pass zeroes the 8192-byte store,
// one byte a cycle; s_axis_tready stays low until that pass is done.
module bloom_filter_hash_insert_probe
	import bfh_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [LOG2_W-1:0] cfg_wdata,     // filter_bits_log2
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [71:0]       s_axis_tdata,  // [63:0] key, [64] start_batch, rest zero
	input  logic              s_axis_tuser,  // [0] opcode
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [71:0]       m_axis_tdata   // [31:0] hash, [32] may_match,
	                                         // [64:33] match_count, rest zero
);

	logic              in_acc;
	item_t             item;
	logic              hash_valid;
	logic [HASH_W-1:0] hash;
	logic              res_valid;
	logic              res_take;
	res_t              res;
	logic              out_valid_q;
	res_t              out_q;

	assign in_acc           = s_axis_tvalid && s_axis_tready;
	assign item.probe       = s_axis_tuser;
	assign item.start_batch = s_axis_tdata[64];

	bfh_hash u_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_acc),
		.in_key    (s_axis_tdata[HASH_W-1:0]),
		.hash_valid(hash_valid),
		.hash      (hash)
	);

	bfh_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.item_accept(in_acc),
		.item       (item),
		.ready      (s_axis_tready),
		.hash_valid (hash_valid),
		.hash       (hash),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.res        (res)
	);

	// output register
	assign res_take = res_valid && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, out_q.match_count, out_q.may_match, out_q.hash};

endmodule

[hw/rtl/bfh_checker.sv]
// Port-level checks for the bloom filter block, bound to the top level.
// Depends on bfh_pkg.
module bfh_checker
	import bfh_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              cfg_we,
	input logic [LOG2_W-1:0] cfg_wdata,
	input logic              s_axis_tvalid,
	input logic              s_axis_tready,
	input logic [71:0]       s_axis_tdata,
	input logic              s_axis_tuser,
	input logic              m_axis_tvalid,
	input logic              m_axis_tready,
	input logic [71:0]       m_axis_tdata
);

	// a held result transaction stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// one item in flight: no new transaction right after one is taken
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second item taken while one is in flight");

	// a reported match implies a nonzero batch count
	a_match_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[64:33] != 32'd0)
		else $error("match reported with zero count");

	// padding of the result word is zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[71:65] == 7'd0)
		else $error("result padding not zero");

endmodule

bind bloom_filter_hash_insert_probe bfh_checker u_bfh_checker (.*);

[dv/bloom_filter_hash_insert_probe_checker.sv]
`timescale 1ns / 100ps
// Checker for bloom_filter_hash_insert_probe: watches both stream channels and
// the size register port, predicts every result and compares field by field.
// Depends on bfh_pkg.
module bloom_filter_hash_insert_probe_checker
	import bfh_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [LOG2_W-1:0] cfg_wdata,
	input  logic              s_axis_tvalid,
	input  logic              s_axis_tready,
	input  logic [71:0]       s_axis_tdata,  // [63:0] key, [64] start_batch
	input  logic              s_axis_tuser,  // [0] opcode
	input  logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	input  logic [71:0]       m_axis_tdata,  // [31:0] hash, [32] may_match, [64:33] match_count
	output int                fail_count,
	output int                pending
);

	logic [7:0]        bit_store [STORE_BYTES];
	logic [CNT_W-1:0]  batch_hits;
	logic [LOG2_W-1:0] size_log2;
	res_t              result_q [$];

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	// hash the low key word, then insert or probe the two derived bit positions
	function automatic res_t filter_step(input item_t it, input logic [31:0] k);
		res_t        r;
		logic [31:0] h;
		logic [31:0] mask;
		logic [31:0] lo_bit;
		logic [31:0] hi_bit;
		int          lg;
		h = k * MUR_C1;
		h = {h[16:0], h[31:17]};
		h = h * MUR_C2;
		h ^= MUR_SEED;
		h ^= h >> 16;
		h = h * FMIX_C1;
		h ^= h >> 13;
		h = h * FMIX_C2;
		h ^= h >> 16;
		lg = size_log2;
		if (lg < LOG2_MIN)
			lg = LOG2_MIN;
		if (lg > BIT_W)
			lg = BIT_W;
		mask = ((32'd1 << lg) - 32'd1) & (FILTER_BITS - 1);
		lo_bit = h & mask;
		hi_bit = (h >> 16) & mask;
		if (it.start_batch)
			batch_hits = '0;
		r.hash = h;
		r.may_match = 1'b0;
		if (it.probe) begin
			if (bit_store[lo_bit[BIT_W-1:3]][lo_bit[2:0]] &&
					bit_store[hi_bit[BIT_W-1:3]][hi_bit[2:0]]) begin
				r.may_match = 1'b1;
				if (batch_hits != CNT_MAX)
					batch_hits++;
			end
		end else begin
			bit_store[lo_bit[BIT_W-1:3]][lo_bit[2:0]] = 1'b1;
			bit_store[hi_bit[BIT_W-1:3]][hi_bit[2:0]] = 1'b1;
		end
		r.match_count = batch_hits;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t  want;
		res_t  got;
		item_t it;
		if (!arst_n) begin
			foreach (bit_store[i])
				bit_store[i] = '0;
			batch_hits = '0;
			size_log2 = LOG2_RESET;
			result_q.delete();
			fail_count = 0;
		end else begin
			// result side first: a result never belongs to an input of the same edge
			if (m_axis_tvalid && m_axis_tready) begin
				got.hash = m_axis_tdata[31:0];
				got.may_match = m_axis_tdata[32];
				got.match_count = m_axis_tdata[64:33];
				if (result_q.size() == 0) begin
					report_mismatch("result transaction with none expected",
						m_axis_tdata[63:0], '0);
				end else begin
					want = result_q.pop_front();
					if (got.hash != want.hash)
						report_mismatch("hash", 64'(got.hash), 64'(want.hash));
					if (got.may_match != want.may_match)
						report_mismatch("may_match", 64'(got.may_match),
							64'(want.may_match));
					if (got.match_count != want.match_count)
						report_mismatch("match_count", 64'(got.match_count),
							64'(want.match_count));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				it.probe = s_axis_tuser;
				it.start_batch = s_axis_tdata[64];
				result_q.push_back(filter_step(it, s_axis_tdata[31:0]));
			end
			if (cfg_we)
				size_log2 = cfg_wdata;
		end
		pending = result_q.size();
	end

endmodule

[dv/bloom_filter_hash_insert_probe_tb.sv]
`timescale 1ns / 100ps
// Top of the bloom_filter_hash_insert_probe testbench: clock, reset, stimulus,
// output backpressure, watchdog and verdict. Depends on bfh_pkg and the checker.
module bloom_filter_hash_insert_probe_tb
	import bfh_pkg::*;
();

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_PROBE  = 1'b1;

	localparam int ITEMS_PER_SETTING = 128;
	localparam int SETTLE_CYCLES     = 10;
	localparam int HOLD_CYCLES       = 300;
	localparam int WATCHDOG_LIMIT    = 30000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [LOG2_W-1:0] cfg_wdata = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [71:0]       s_axis_tdata = '0;
	logic              s_axis_tuser = 1'b0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [71:0]       m_axis_tdata;

	int checker_fails;
	int results_pending;
	int idle_cycles = 0;
	int hold_requests = 0;
	int holds_served = 0;
	logic quiet = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	bloom_filter_hash_insert_probe dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	bloom_filter_hash_insert_probe_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (checker_fails),
		.pending       (results_pending)
	);

	// stalls while nothing moves; the clearing pass after reset is the longest quiet span
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("FAIL bloom_filter_hash_insert_probe");
			$finish;
		end
	end

	// receiver: random backpressure, plus a long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (holds_served != hold_requests) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				holds_served++;
			end
			m_axis_tready <= quiet || ($urandom_range(99) >= 15);
		end
	end

	task automatic send_item(input logic op, input logic [63:0] key, input logic sb);
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'b0, sb, key};
		s_axis_tuser <= op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic idle_gap(input int cycles);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic wait_all_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (results_pending != 0)
			@(negedge clk);
	endtask

	initial begin
		logic [LOG2_W-1:0] size_plan [12];
		logic [31:0]       key_pool [$];
		logic [63:0]       key;
		logic              op;
		int                ph;
		int                n;
		size_plan = '{5'd3, 5'd0, 5'd31, 5'd8, 5'd17, 5'd1, 5'd12, 5'd2, 5'd16, 5'd0,
			5'd5, 5'd4};
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// directed part at the reset size: empty-filter miss, hits through
		// different upper key words, extreme keys, start_batch on both opcodes
		send_item(OP_PROBE,  64'h0000_0000_0000_0000, 1'b1);
		send_item(OP_INSERT, 64'h0000_0000_0000_0000, 1'b0);
		send_item(OP_PROBE,  64'h0000_0000_0000_0000, 1'b0);
		send_item(OP_PROBE,  64'hffff_ffff_0000_0000, 1'b0);
		send_item(OP_INSERT, 64'hffff_ffff_ffff_ffff, 1'b0);
		send_item(OP_PROBE,  64'hffff_ffff_ffff_ffff, 1'b0);
		send_item(OP_INSERT, 64'h7fff_ffff_ffff_ffff, 1'b0);
		send_item(OP_INSERT, 64'h8000_0000_0000_0000, 1'b0);
		send_item(OP_PROBE,  64'h8000_0000_0000_0000, 1'b1);
		send_item(OP_INSERT, 64'h1234_5678_9abc_def0, 1'b1);
		send_item(OP_PROBE,  64'h0000_0000_ffff_ffff, 1'b0);
		send_item(OP_PROBE,  64'h5555_5555_5555_5555, 1'b0);
		send_item(OP_INSERT, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
		send_item(OP_PROBE,  64'haaaa_aaaa_aaaa_aaaa, 1'b0);
		send_item(OP_PROBE,  64'h0000_0000_8000_0000, 1'b0);
		send_item(OP_INSERT, 64'h0000_0000_0000_0001, 1'b0);
		send_item(OP_PROBE,  64'h8000_0000_0000_0001, 1'b0);
		send_item(OP_PROBE,  64'h1234_5678_9abc_def0, 1'b1);

		for (ph = 0; ph < 12; ph++) begin
			wait_all_results();
			repeat (SETTLE_CYCLES) @(negedge clk);
			cfg_we <= 1'b1;
			cfg_wdata <= (ph == 9) ? LOG2_W'($urandom_range(16, 3)) : size_plan[ph];
			@(negedge clk);
			cfg_we <= 1'b0;
			quiet <= (ph == 3);
			for (n = 0; n < ITEMS_PER_SETTING; n++) begin
				if (ph != 3 && $urandom_range(99) < 15)
					idle_gap($urandom_range(8, 1));
				if (ph == 1 && n == 40)
					hold_requests++;
				if (ph == 5 && n == 60)
					wait_all_results();
				op = $urandom_range(1) ? OP_PROBE : OP_INSERT;
				key = {$urandom, $urandom};
				// probes mostly look up keys already inserted, so hits stay common
				if (key_pool.size() != 0 &&
						$urandom_range(99) < ((op == OP_PROBE) ? 60 : 30)) begin
					key[31:0] = key_pool[$urandom_range(key_pool.size() - 1)];
				end else if (op == OP_INSERT) begin
					key_pool.push_back(key[31:0]);
					if (key_pool.size() > 64)
						void'(key_pool.pop_front());
				end
				send_item(op, key, $urandom_range(99) < 5);
			end
		end

		wait_all_results();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (checker_fails == 0 && results_pending == 0)
			$display("PASS bloom_filter_hash_insert_probe");
		else
			$display("FAIL bloom_filter_hash_insert_probe");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/bfh_pkg.sv
hw/rtl/bfh_ram.sv
hw/rtl/bfh_hash.sv
hw/rtl/bfh_core.sv
hw/rtl/bloom_filter_hash_insert_probe.sv
hw/rtl/bfh_checker.sv
dv/bloom_filter_hash_insert_probe_checker.sv
dv/bloom_filter_hash_insert_probe_tb.sv
